/* src/tqa_pkg.sv */
// Shared types and constants for the topic queue with aging.
// No dependencies; imported by the top level, both checkers and the testbench.
package tqa_pkg;

  localparam int TopicCountDefault = 8;
  localparam int QueueDepthDefault = 32;
  localparam logic [15:0] AgeLimitReset = 16'd5;

  typedef enum logic [1:0] {
    OP_PUBLISH = 2'd0,
    OP_FETCH   = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_PUBLISHED = 3'd0,
    ST_FULL      = 3'd1,
    ST_EXACT     = 3'd2,
    ST_LATER     = 3'd3,
    ST_NOTHING   = 3'd4,
    ST_TICKED    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_READ,
    S_READ_WAIT,
    S_TICK,
    S_TICK_WAIT,
    S_DONE
  } state_t;

endpackage

/* src/topic_queue_with_aging_core.sv */
// Top level of the topic queue with aging: sequencer, per-topic pointers and
// the shared compare unit. Depends on tqa_pkg and tqa_store.
//
// Channel | Ports                                      | Handshake
// input   | in_op in_topic in_last_seen in_label_in .. | start & !busy
// result  | out_status out_seq_out .. out_evicted_count| out_valid, one cycle
// config  | cfg_we cfg_age_limit                       | cfg_we
//
// A publish answers straight from idle; a fetch makes one memory read and one
// compare per stored entry through the single read port, then rereads a later
// match; a tick makes one head read per topic.
// Results show for one cycle; busy stays high until then, and the receiver
// cannot stall a result beat. Reset clears pointers, counts and time; the
// entry memory needs no clearing since only live entries are read.
module topic_queue_with_aging_core
  import tqa_pkg::*;
#(
  parameter int TopicCount = TopicCountDefault,
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [2:0]  in_topic,
  input  logic [31:0] in_last_seen,
  input  logic [7:0]  in_label_in,
  input  logic [31:0] in_payload_in,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_seq_out,
  output logic [31:0] out_stamp_out,
  output logic [7:0]  out_label_out,
  output logic [31:0] out_payload_out,
  output logic [3:0]  out_evicted_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_age_limit
);
  localparam int TW = (TopicCount > 1) ? $clog2(TopicCount) : 1;
  localparam int PW = $clog2(QueueDepth);
  localparam int CW = $clog2(QueueDepth + 1);
  localparam int AW = TW + PW;
  localparam int Depth = 1 << AW;
  localparam int EW = $clog2(TopicCount + 1);

  state_t state_r, state_nxt;

  logic [PW-1:0] head_r [TopicCount];
  logic [PW-1:0] tail_r [TopicCount];
  logic [CW-1:0] fill_r [TopicCount];
  logic [31:0]   total_r [TopicCount];
  logic [31:0]   now_r;
  logic [15:0]   age_limit_r;

  logic [TW-1:0] topic_r;
  logic [32:0]   target_r;
  logic [CW-1:0] idx_r;
  logic [PW-1:0] pos_r;
  logic          found_r;
  logic [PW-1:0] hit_pos_r;
  logic [EW-1:0] evict_r;
  logic [2:0]    status_r;
  logic [31:0]   seq_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   rd_seq, rd_stamp, rd_payload;
  logic [7:0]    rd_label;
  logic          topic_ok;
  logic [TW-1:0] in_t;
  logic [31:0]   new_seq;
  logic [31:0]   age;
  logic          cmp_eq, cmp_gt, evict_now;

  assign in_t     = TW'(in_topic);
  assign topic_ok = ({29'd0, in_topic} < 32'(TopicCount));
  assign new_seq  = (total_r[in_t] == 32'hFFFF_FFFF) ? total_r[in_t] : total_r[in_t] + 32'd1;

  // Shared compare unit: used for fetch search and tick age check.
  assign cmp_eq = ({1'b0, rd_seq} == target_r);
  assign cmp_gt = ({1'b0, rd_seq} > target_r);
  assign age    = now_r - rd_stamp;
  assign evict_now = (fill_r[topic_r] != '0) && (age > {16'd0, age_limit_r});

  // Memory addressing.
  assign wr_en   = (state_r == S_IDLE) && start && (op_t'(in_op) == OP_PUBLISH) && topic_ok
                   && (fill_r[in_t] < CW'(QueueDepth));
  assign wr_addr = {in_t, tail_r[in_t]};
  always_comb begin
    case (state_r)
      S_READ:      rd_addr = {topic_r, hit_pos_r};
      S_READ_WAIT: rd_addr = {topic_r, hit_pos_r};
      S_TICK:      rd_addr = {topic_r, head_r[topic_r]};
      default:     rd_addr = {topic_r, pos_r};
    endcase
  end

  tqa_store #(.Depth(Depth)) u_store (
    .clk, .wr_en, .wr_addr,
    .wr_seq(new_seq), .wr_stamp(now_r), .wr_label(in_label_in), .wr_payload(in_payload_in),
    .rd_addr, .rd_seq, .rd_stamp, .rd_label, .rd_payload
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:
        if (start) begin
          case (op_t'(in_op))
            OP_FETCH: state_nxt = (topic_ok && fill_r[in_t] != '0) ? S_SCAN : S_DONE;
            OP_TICK:  state_nxt = S_TICK;
            default:  state_nxt = S_DONE;
          endcase
        end
      S_SCAN:      state_nxt = S_SCAN_WAIT;
      S_SCAN_WAIT: begin
        if (cmp_eq) state_nxt = S_DONE;
        else if (idx_r + CW'(1) >= fill_r[topic_r]) state_nxt = (found_r || cmp_gt) ? S_READ : S_DONE;
        else state_nxt = S_SCAN;
      end
      S_READ:      state_nxt = S_READ_WAIT;
      S_READ_WAIT: state_nxt = S_DONE;
      S_TICK:      state_nxt = S_TICK_WAIT;
      S_TICK_WAIT: state_nxt = (32'(topic_r) == 32'(TopicCount - 1)) ? S_DONE : S_TICK;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy              = (state_r != S_IDLE);
    out_valid         = (state_r == S_DONE);
    out_status        = status_r;
    out_seq_out       = seq_r;
    out_stamp_out     = '0;
    out_label_out     = '0;
    out_payload_out   = '0;
    out_evicted_count = 4'(evict_r);
    if (status_r == ST_EXACT || status_r == ST_LATER) begin
      out_stamp_out   = rd_stamp;
      out_label_out   = rd_label;
      out_payload_out = rd_payload;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      age_limit_r <= AgeLimitReset;
      for (int i = 0; i < TopicCount; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        fill_r[i]  <= '0;
        total_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) age_limit_r <= cfg_age_limit;
      if (wr_en) begin
        total_r[in_t] <= new_seq;
        tail_r[in_t]  <= (32'(tail_r[in_t]) == QueueDepth - 1) ? '0 : tail_r[in_t] + PW'(1);
        fill_r[in_t]  <= fill_r[in_t] + CW'(1);
      end
      if (state_r == S_IDLE && start && op_t'(in_op) == OP_TICK) now_r <= now_r + 32'd1;
      if (state_r == S_TICK_WAIT && evict_now) begin
        head_r[topic_r] <= (32'(head_r[topic_r]) == QueueDepth - 1) ? '0
                           : head_r[topic_r] + PW'(1);
        fill_r[topic_r] <= fill_r[topic_r] - CW'(1);
      end
    end
  end

  // Working registers of the current beat.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (start) begin
        topic_r  <= (op_t'(in_op) == OP_TICK) ? '0 : in_t;
        target_r <= {1'b0, in_last_seen} + 33'd1;
        idx_r    <= '0;
        pos_r    <= head_r[in_t];
        found_r  <= 1'b0;
        evict_r  <= '0;
        seq_r    <= '0;
        case (op_t'(in_op))
          OP_PUBLISH: begin
            status_r <= wr_en ? ST_PUBLISHED : ST_FULL;
            if (wr_en) seq_r <= new_seq;
          end
          OP_TICK: status_r <= ST_TICKED;
          default: status_r <= ST_NOTHING;
        endcase
      end
      S_SCAN_WAIT: begin
        idx_r <= idx_r + CW'(1);
        pos_r <= (32'(pos_r) == QueueDepth - 1) ? '0 : pos_r + PW'(1);
        if (cmp_eq) begin
          status_r <= ST_EXACT;
          seq_r    <= rd_seq;
        end else if (!found_r && cmp_gt) begin
          found_r   <= 1'b1;
          hit_pos_r <= pos_r;
          status_r  <= ST_LATER;
        end
      end
      S_READ_WAIT: seq_r <= rd_seq;
      S_TICK_WAIT: begin
        if (evict_now) evict_r <= evict_r + EW'(1);
        if (32'(topic_r) != TopicCount - 1) topic_r <= topic_r + TW'(1);
      end
      default: ;
    endcase
  end
endmodule

/* src/tqa_store.sv */
// Entry memory: sequence, stamp, label and payload per slot, one write and
// one registered read port. Depends on nothing but its parameters.
module tqa_store #(
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [31:0]              wr_seq,
  input  logic [31:0]              wr_stamp,
  input  logic [7:0]               wr_label,
  input  logic [31:0]              wr_payload,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [31:0]              rd_seq,
  output logic [31:0]              rd_stamp,
  output logic [7:0]               rd_label,
  output logic [31:0]              rd_payload
);
  logic [31:0] seq_mem [Depth];
  logic [31:0] stamp_mem [Depth];
  logic [7:0]  label_mem [Depth];
  logic [31:0] payload_mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      seq_mem[wr_addr]     <= wr_seq;
      stamp_mem[wr_addr]   <= wr_stamp;
      label_mem[wr_addr]   <= wr_label;
      payload_mem[wr_addr] <= wr_payload;
    end
    rd_seq     <= seq_mem[rd_addr];
    rd_stamp   <= stamp_mem[rd_addr];
    rd_label   <= label_mem[rd_addr];
    rd_payload <= payload_mem[rd_addr];
  end
endmodule

/* src/tqa_checker.sv */
// Port-level checker for the topic queue with aging, bound to the top level.
// Depends on tqa_pkg.
module tqa_checker
  import tqa_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic [3:0] out_evicted_count
);
  // An accepted beat makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted beat not busy");
  // A result ends the busy period.
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  // A result shows only while busy.
  a_vbusy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  // Evictions are reported only with a tick result.
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_TICKED |-> out_evicted_count == 4'd0)
    else $error("eviction count on non-tick result");
endmodule

bind topic_queue_with_aging_core tqa_checker u_tqa_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_status, .out_evicted_count
);

/* dv/topic_queue_with_aging_checker.sv */
// Result checker for the topic queue with aging: predicts each answer from the
// accepted command beats and compares it with the result beats. Uses tqa_pkg.
module topic_queue_with_aging_checker
  import tqa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_op,
  input  logic [2:0]  in_topic,
  input  logic [31:0] in_last_seen,
  input  logic [7:0]  in_label_in,
  input  logic [31:0] in_payload_in,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_seq_out,
  input  logic [31:0] out_stamp_out,
  input  logic [7:0]  out_label_out,
  input  logic [31:0] out_payload_out,
  input  logic [3:0]  out_evicted_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_age_limit,
  output int          fail_count,
  output int          pending_count,
  output int          answer_count
);

  localparam int Topics = TopicCountDefault;
  localparam int Depth  = QueueDepthDefault;

  typedef struct packed {
    status_t     status;
    logic [31:0] seq;
    logic [31:0] stamp;
    logic [7:0]  label;
    logic [31:0] payload;
    logic [3:0]  evicted;
  } answer_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] stamp;
    logic [7:0]  label;
    logic [31:0] payload;
  } entry_t;

  // Mirror of the queue state.
  entry_t      slots [Topics][Depth];
  int unsigned head_pos [Topics];
  int unsigned tail_pos [Topics];
  int unsigned fill [Topics];
  logic [31:0] seq_total [Topics];
  logic [31:0] clock_ticks;
  logic [15:0] max_age;
  answer_t     expected_answers [$];

  function automatic answer_t entry_answer(status_t st, entry_t e);
    answer_t r;
    r = '0;
    r.status = st;
    r.seq = e.seq;
    r.stamp = e.stamp;
    r.label = e.label;
    r.payload = e.payload;
    return r;
  endfunction

  // Apply one command beat to the mirror and return its answer.
  function automatic answer_t predict_answer(op_t op, int unsigned tp, logic [31:0] last,
                                             logic [7:0] label, logic [31:0] payload);
    answer_t     r;
    logic [32:0] target;
    int unsigned hit;
    bit          later;
    logic [31:0] age;
    entry_t      e;
    r = '0;
    r.status = ST_NOTHING;
    case (op)
      OP_PUBLISH: begin
        if (fill[tp] >= Depth) begin
          r.status = ST_FULL;
        end else begin
          if (seq_total[tp] != 32'hFFFF_FFFF) seq_total[tp]++;
          e.seq = seq_total[tp];
          e.stamp = clock_ticks;
          e.label = label;
          e.payload = payload;
          slots[tp][tail_pos[tp]] = e;
          tail_pos[tp] = (tail_pos[tp] + 1) % Depth;
          fill[tp]++;
          r.status = ST_PUBLISHED;
          r.seq = seq_total[tp];
        end
      end
      OP_FETCH: begin
        target = {1'b0, last} + 33'd1;
        later = 0;
        hit = 0;
        for (int i = 0; i < fill[tp]; i++) begin
          e = slots[tp][(head_pos[tp] + i) % Depth];
          if ({1'b0, e.seq} == target) return entry_answer(ST_EXACT, e);
          if (!later && {1'b0, e.seq} > target) begin
            later = 1;
            hit = (head_pos[tp] + i) % Depth;
          end
        end
        if (later) r = entry_answer(ST_LATER, slots[tp][hit]);
      end
      OP_TICK: begin
        clock_ticks++;
        for (int t = 0; t < Topics; t++) begin
          if (fill[t] != 0) begin
            age = clock_ticks - slots[t][head_pos[t]].stamp;
            if (age > {16'd0, max_age}) begin
              head_pos[t] = (head_pos[t] + 1) % Depth;
              fill[t]--;
              r.evicted++;
            end
          end
        end
        r.status = ST_TICKED;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_count = expected_answers.size();

  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst_n) begin
      max_age <= AgeLimitReset;
      clock_ticks = '0;
      for (int t = 0; t < Topics; t++) begin
        head_pos[t] = 0;
        tail_pos[t] = 0;
        fill[t] = 0;
        seq_total[t] = '0;
      end
      expected_answers.delete();
      fail_count <= 0;
      answer_count <= 0;
    end else begin
      if (cfg_we) max_age <= cfg_age_limit;
      // Compare the result beat with the oldest expectation.
      if (out_valid) begin
        answer_count <= answer_count + 1;
        if (expected_answers.size() == 0) begin
          $error("result beat with no command waiting, status %0d", out_status);
          fail_count <= fail_count + 1;
        end else begin
          exp_a = expected_answers.pop_front();
          if (out_status !== exp_a.status || out_seq_out !== exp_a.seq ||
              out_stamp_out !== exp_a.stamp || out_label_out !== exp_a.label ||
              out_payload_out !== exp_a.payload || out_evicted_count !== exp_a.evicted)
            fail_count <= fail_count + 1;
          if (out_status !== exp_a.status)
            $error("status: expected %0d, got %0d", exp_a.status, out_status);
          if (out_seq_out !== exp_a.seq)
            $error("seq_out: expected %0d, got %0d", exp_a.seq, out_seq_out);
          if (out_stamp_out !== exp_a.stamp)
            $error("stamp_out: expected %0d, got %0d", exp_a.stamp, out_stamp_out);
          if (out_label_out !== exp_a.label)
            $error("label_out: expected %0d, got %0d", exp_a.label, out_label_out);
          if (out_payload_out !== exp_a.payload)
            $error("payload_out: expected %h, got %h", exp_a.payload, out_payload_out);
          if (out_evicted_count !== exp_a.evicted)
            $error("evicted_count: expected %0d, got %0d", exp_a.evicted,
                   out_evicted_count);
        end
      end
      // Predict the answer of an accepted command beat.
      if (start && !busy)
        expected_answers.push_back(predict_answer(op_t'(in_op), in_topic, in_last_seen,
                                                  in_label_in, in_payload_in));
    end
  end

endmodule

/* dv/topic_queue_with_aging_core_tb.sv */
// Testbench top for topic_queue_with_aging_core: drives command and config
// beats and gives the verdict. Uses tqa_pkg and topic_queue_with_aging_checker.
module topic_queue_with_aging_core_tb;
  import tqa_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [2:0]  in_topic;
  logic [31:0] in_last_seen;
  logic [7:0]  in_label_in;
  logic [31:0] in_payload_in;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_seq_out;
  logic [31:0] out_stamp_out;
  logic [7:0]  out_label_out;
  logic [31:0] out_payload_out;
  logic [3:0]  out_evicted_count;
  logic        cfg_we;
  logic [15:0] cfg_age_limit;
  int          fail_count;
  int          pending_count;
  int          answer_count;
  int          beats_sent;

  topic_queue_with_aging_core i_dut (.*);

  topic_queue_with_aging_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Random idle gap: mostly short, now and then long.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    repeat (n) @(posedge clk);
  endtask

  // Send one command beat and hold it until the block takes it. The block is
  // busy after each accepted beat, so the extra edge costs nothing.
  task automatic send_command(op_t op, logic [2:0] tp, logic [31:0] last,
                              logic [7:0] label, logic [31:0] payload);
    start <= 1'b1;
    in_op <= op;
    in_topic <= tp;
    in_last_seen <= last;
    in_label_in <= label;
    in_payload_in <= payload;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    beats_sent++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_age_limit(logic [15:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_age_limit <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random command with a mix of well-formed reads near live numbers.
  task automatic random_command(int tick_weight);
    int          pick;
    logic [31:0] last;
    logic [2:0]  tp;
    logic [7:0]  label;
    logic [31:0] payload;
    pick = $urandom_range(0, 99);
    last = $urandom_range(0, 40);
    if ($urandom_range(0, 9) == 0) last = $urandom();
    tp = 3'($urandom_range(0, 7));
    label = 8'($urandom());
    payload = $urandom();
    if (pick < 45)
      send_command(OP_PUBLISH, tp, last, label, payload);
    else if (pick < 100 - tick_weight - 3)
      send_command(OP_FETCH, tp, last, label, payload);
    else if (pick < 97)
      send_command(OP_TICK, tp, last, label, payload);
    else
      send_command(OP_NONE, tp, last, label, payload);
  endtask

  initial begin
    logic [15:0] limits [4];
    limits = '{16'd0, 16'd3, 16'hFFFF, 16'd20};
    beats_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_age_limit = '0;
    in_op = OP_PUBLISH;
    in_topic = '0;
    in_last_seen = '0;
    in_label_in = '0;
    in_payload_in = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every op, full queue, top last_seen, spare op code.
    send_command(OP_FETCH, 3'd0, 32'd0, 8'd0, 32'd0);
    send_command(OP_PUBLISH, 3'd7, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send_command(OP_PUBLISH, 3'd7, 32'd0, 8'h00, 32'h0000_0000);
    send_command(OP_FETCH, 3'd7, 32'd0, 8'd0, 32'd0);
    send_command(OP_FETCH, 3'd7, 32'd5, 8'd0, 32'd0);
    send_command(OP_FETCH, 3'd7, 32'hFFFF_FFFF, 8'd0, 32'd0);
    for (int i = 0; i < 33; i++)
      send_command(OP_PUBLISH, 3'd2, 32'd0, i[7:0], {24'd0, i[7:0]});
    send_command(OP_FETCH, 3'd2, 32'd31, 8'd0, 32'd0);
    send_command(OP_NONE, 3'd5, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 7; i++) send_command(OP_TICK, 3'd0, 32'd0, 8'd0, 32'd0);
    send_command(OP_FETCH, 3'd2, 32'd0, 8'd0, 32'd0);

    // Random phases over several age limits; the sender drains between them.
    foreach (limits[k]) begin
      write_age_limit(limits[k]);
      for (int n = 0; n < 270; n++) begin
        if ($urandom_range(0, 3) != 0) idle_gap();
        random_command(k == 2 ? 5 : 20);
      end
    end
    wait_drained();
    $display("Covered %0d command beats and %0d result beats over four age limits.",
             beats_sent, answer_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
